// ===== sv/befrl_pkg.sv =====
// Shared types, constants and helpers for the bus event filter and RLE trace logger.
package befrl_pkg;

   localparam int ADDR_W     = 21;
   localparam int WORD_W     = 32;
   localparam int RUN_W      = 24;
   localparam int RULE_W     = 21;
   localparam int CAP_W      = 22;
   localparam int PORT_W     = 10;
   localparam int DATA_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 22;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_RULE_A   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RULE_B   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RULE_C   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RULE_D   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CAPACITY = 3'd4;
   localparam int RULE_REG_COUNT = 4;

   localparam logic MODE_CAPTURE = 1'b0;
   localparam logic MODE_FLUSH   = 1'b1;

   localparam logic [7:0]        TRAILER_TAG = 8'hFF;
   localparam logic [RUN_W-1:0]  RUN_LIMIT   = 24'hFF_FFFF;
   localparam int unsigned       ADDR_SPACE  = 2097152;

   localparam logic [RULE_W-1:0] RULE_A_RESET = 21'h1F_C220;
   localparam logic [RULE_W-1:0] RULE_B_RESET = 21'h1F_F388;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic                  en;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_wr_type;

   // one pending run handed from the front end to the ring writer
   typedef struct packed {
      logic [WORD_W-1:0] event_word;
      logic              has_trailer;
      logic [RUN_W-1:0]  trailer_count;
   } job_type;

   // reset value of rule slot i; slots past the second start disabled
   function automatic logic [RULE_W-1:0] rule_reset(input int i);
      logic [RULE_W-1:0] r;
      r = '0;
      if (i == 0) begin
         r = RULE_A_RESET;
      end else if (i == 1) begin
         r = RULE_B_RESET;
      end
      return r;
   endfunction

endpackage

// ===== sv/befrl_fifo.sv =====
// Small register queue of pending runs between the front end and the ring writer.
module befrl_fifo #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  befrl_pkg::job_type  push_data,
   output logic                full,
   input  logic                pop,
   output befrl_pkg::job_type  pop_data,
   output logic                empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   befrl_pkg::job_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/befrl_front.sv =====
// Front end: port filter, event packing and run-length tracking.
module befrl_front #(
   parameter int FILTER_RULES = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  befrl_pkg::csr_wr_type                csr,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_mode,
   input  logic                                 req_is_read,
   input  logic [31:0]                          req_raw_capture,
   input  logic                                 q_full,
   output logic                                 job_push,
   output befrl_pkg::job_type                   job
);

   logic [befrl_pkg::RULE_W-1:0] rule_ff [FILTER_RULES];
   logic [befrl_pkg::RULE_W-1:0] rule_in [FILTER_RULES];
   logic [befrl_pkg::WORD_W-1:0] held_ff, held_in;
   logic [befrl_pkg::RUN_W-1:0]  run_ff, run_in;

   logic [befrl_pkg::PORT_W-1:0] port;
   logic [befrl_pkg::DATA_W-1:0] data;
   logic                         dma;
   logic                         match;
   logic                         keep;
   logic                         accept;
   logic                         emit;
   logic [befrl_pkg::WORD_W-1:0] ev;

   assign port   = req_raw_capture[31:22];
   assign data   = req_raw_capture[21:14];
   assign dma    = req_raw_capture[13];
   assign ev     = {req_is_read, dma, 12'd0, port, data};
   assign keep   = dma || match;
   assign req_ready = !q_full;
   assign accept = req_valid && req_ready;

   always_comb begin
      match = 1'b0;
      for (int i = 0; i < FILTER_RULES; i++) begin
         if (rule_ff[i][20] &&
             (((port ^ rule_ff[i][9:0]) & rule_ff[i][19:10]) == '0)) begin
            match = 1'b1;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < FILTER_RULES; i++) begin
         rule_in[i] = rule_ff[i];
         if (i < befrl_pkg::RULE_REG_COUNT && csr.en &&
             csr.index == befrl_pkg::CSR_IDX_W'(i)) begin
            rule_in[i] = csr.data[befrl_pkg::RULE_W-1:0];
         end
      end
   end

   always_comb begin
      emit    = 1'b0;
      held_in = held_ff;
      run_in  = run_ff;
      if (accept) begin
         if (req_mode == befrl_pkg::MODE_FLUSH) begin
            if (run_ff != '0) begin
               emit   = 1'b1;
               run_in = '0;
            end
         end else if (keep) begin
            if (run_ff == '0) begin
               held_in = ev;
               run_in  = befrl_pkg::RUN_W'(1);
            end else if (ev == held_ff && run_ff != befrl_pkg::RUN_LIMIT) begin
               run_in = run_ff + befrl_pkg::RUN_W'(1);
            end else begin
               emit    = 1'b1;
               held_in = ev;
               run_in  = befrl_pkg::RUN_W'(1);
            end
         end
      end
   end

   assign job_push          = emit;
   assign job.event_word    = held_ff;
   assign job.has_trailer   = (run_ff[befrl_pkg::RUN_W-1:1] != '0);
   assign job.trailer_count = run_ff - befrl_pkg::RUN_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         run_ff  <= '0;
         for (int i = 0; i < FILTER_RULES; i++) begin
            rule_ff[i] <= befrl_pkg::rule_reset(i);
         end
      end else begin
         held_ff <= held_in;
         run_ff  <= run_in;
         for (int i = 0; i < FILTER_RULES; i++) begin
            rule_ff[i] <= rule_in[i];
         end
      end
   end

endmodule

// ===== sv/befrl_back.sv =====
// Back end: ring pointer, wrap flag and the registered result stage.
module befrl_back #(
   parameter int unsigned MAX_RING_WORDS = 2097152
) (
   input  logic                                clock,
   input  logic                                reset,
   input  befrl_pkg::csr_wr_type               csr,
   input  befrl_pkg::job_type                  job,
   input  logic                                q_empty,
   output logic                                job_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [befrl_pkg::ADDR_W-1:0]        rsp_write_address,
   output logic [befrl_pkg::WORD_W-1:0]        rsp_write_word,
   output logic                                rsp_ring_wrapped,
   output logic                                rsp_last_of_run
);

   localparam int unsigned CAP_LIMIT_INT = (MAX_RING_WORDS < befrl_pkg::ADDR_SPACE) ?
                                           MAX_RING_WORDS : befrl_pkg::ADDR_SPACE;
   localparam logic [befrl_pkg::CAP_W-1:0] CAP_LIMIT = befrl_pkg::CAP_W'(CAP_LIMIT_INT);

   localparam logic PHASE_EVENT   = 1'b0;
   localparam logic PHASE_TRAILER = 1'b1;

   logic [befrl_pkg::CAP_W-1:0]  cap_ff, cap_in;
   logic [befrl_pkg::ADDR_W-1:0] wp_ff, wp_in;
   logic                         wrapped_ff, wrapped_in;
   logic                         phase_ff, phase_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [befrl_pkg::ADDR_W-1:0] addr_ff;
   logic [befrl_pkg::WORD_W-1:0] word_ff, word_in;
   logic                         wrap_out_ff;
   logic                         last_ff, last_in;

   logic                         load;
   logic                         over;
   logic                         at_end;
   logic [befrl_pkg::ADDR_W-1:0] addr;
   logic [befrl_pkg::CAP_W-1:0]  next;

   // capacity is stored already clamped
   always_comb begin
      cap_in = cap_ff;
      if (csr.en && csr.index == befrl_pkg::REG_CAPACITY) begin
         if (csr.data == '0) begin
            cap_in = befrl_pkg::CAP_W'(1);
         end else if (csr.data > CAP_LIMIT) begin
            cap_in = CAP_LIMIT;
         end else begin
            cap_in = csr.data;
         end
      end
   end

   assign load    = !q_empty && (!rsp_valid_ff || rsp_ready);
   assign over    = ({1'b0, wp_ff} >= cap_ff);
   assign addr    = over ? '0 : wp_ff;
   assign next    = {1'b0, addr} + befrl_pkg::CAP_W'(1);
   assign at_end  = (next >= cap_ff);

   always_comb begin
      wp_in        = wp_ff;
      wrapped_in   = wrapped_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      word_in      = job.event_word;
      last_in      = !job.has_trailer;
      if (phase_ff == PHASE_TRAILER) begin
         word_in = {befrl_pkg::TRAILER_TAG, job.trailer_count};
         last_in = 1'b1;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         wp_in        = at_end ? '0 : next[befrl_pkg::ADDR_W-1:0];
         wrapped_in   = wrapped_ff || over || at_end;
         phase_in     = last_in ? PHASE_EVENT : PHASE_TRAILER;
      end
   end

   assign job_pop = load && last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_LIMIT;
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         phase_ff     <= PHASE_EVENT;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         wp_ff        <= wp_in;
         wrapped_ff   <= wrapped_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         addr_ff     <= addr;
         word_ff     <= word_in;
         wrap_out_ff <= wrapped_in;
         last_ff     <= last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_address = addr_ff;
   assign rsp_write_word    = word_ff;
   assign rsp_ring_wrapped  = wrap_out_ff;
   assign rsp_last_of_run   = last_ff;

endmodule

// ===== sv/bus_event_filter_rle_logger.sv =====
// Top level of the bus event filter with run-length encoded trace ring writer.
//
//   channel  direction  transaction
//   req_*    in         captured bus cycle (mode 0) or flush of the pending run (mode 1)
//   rsp_*    out        one ring write: address, word, wrapped flag, last-of-run mark
//   csr_*    in         register write, index 0..3 port rules, 4 ring capacity
//
// A request is taken every cycle while the run queue has room; filtering and run
// tracking finish in the cycle of acceptance. A closed run leaves the ring writer as
// one or two writes at one write per cycle while rsp_ready holds, and a sustained load
// of runs with trailers is paced by the single result register, which holds one write.
// Reset is synchronous; it restores the default rules and capacity and clears the run,
// pointer and wrap flag. A result held on rsp_* waits for rsp_ready while requests keep
// flowing into the queue until it fills.
module bus_event_filter_rle_logger #(
   parameter int unsigned MAX_RING_WORDS = 2097152,
   parameter int          FILTER_RULES   = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_mode,
   input  logic                                   req_is_read,
   input  logic [31:0]                            req_raw_capture,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [befrl_pkg::ADDR_W-1:0]           rsp_write_address,
   output logic [befrl_pkg::WORD_W-1:0]           rsp_write_word,
   output logic                                   rsp_ring_wrapped,
   output logic                                   rsp_last_of_run,
   input  logic                                   csr_write_en,
   input  logic [befrl_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [befrl_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   befrl_pkg::csr_wr_type csr;
   befrl_pkg::job_type    push_job;
   befrl_pkg::job_type    head_job;
   logic                  job_push;
   logic                  job_pop;
   logic                  q_full;
   logic                  q_empty;

   assign csr.en    = csr_write_en;
   assign csr.index = csr_index;
   assign csr.data  = csr_wdata;

   befrl_front #(
      .FILTER_RULES (FILTER_RULES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr             (csr),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_is_read     (req_is_read),
      .req_raw_capture (req_raw_capture),
      .q_full          (q_full),
      .job_push        (job_push),
      .job             (push_job)
   );

   befrl_fifo #(
      .DEPTH (befrl_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .full      (q_full),
      .pop       (job_pop),
      .pop_data  (head_job),
      .empty     (q_empty)
   );

   befrl_back #(
      .MAX_RING_WORDS (MAX_RING_WORDS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .csr               (csr),
      .job               (head_job),
      .q_empty           (q_empty),
      .job_pop           (job_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_write_address (rsp_write_address),
      .rsp_write_word    (rsp_write_word),
      .rsp_ring_wrapped  (rsp_ring_wrapped),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

// ===== sv/befrl_checker.sv =====
// Port-level checks for the trace logger, bound to the top level.
module befrl_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [befrl_pkg::ADDR_W-1:0]      rsp_write_address,
   input  logic [befrl_pkg::WORD_W-1:0]      rsp_write_word,
   input  logic                              rsp_ring_wrapped,
   input  logic                              rsp_last_of_run
);

   logic rsp_fire;
   logic seen_wrap_ff;
   logic mid_run_ff;

   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_wrap_ff <= 1'b0;
         mid_run_ff   <= 1'b0;
      end else if (rsp_fire) begin
         seen_wrap_ff <= seen_wrap_ff || rsp_ring_wrapped;
         mid_run_ff   <= !rsp_last_of_run;
      end
   end

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_write_word) &&
      $stable(rsp_write_address) && $stable(rsp_last_of_run))
      else $error("rsp payload changed while stalled");

   // no result comes out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // wrap flag never clears once reported
   a_wrap_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && seen_wrap_ff |-> rsp_ring_wrapped)
      else $error("ring_wrapped dropped");

   // an event word that is not last is followed by its trailer
   a_trailer_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && mid_run_ff |->
      rsp_last_of_run && rsp_write_word[31:24] == befrl_pkg::TRAILER_TAG)
      else $error("missing trailer after event word");

   // an event word that is not last never carries the trailer tag
   a_event_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_last_of_run |-> rsp_write_word[31:24] != befrl_pkg::TRAILER_TAG)
      else $error("non-final write looks like a trailer");

endmodule

bind bus_event_filter_rle_logger befrl_checker u_befrl_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_write_address (rsp_write_address),
   .rsp_write_word    (rsp_write_word),
   .rsp_ring_wrapped  (rsp_ring_wrapped),
   .rsp_last_of_run   (rsp_last_of_run)
);
